// ===== rtl/indel_interval_clusterer_top_defines.svh =====
// Assertion macros for the indel interval clusterer.
// Used by the top level; they expect a clock named clk and a reset named rst.
`ifndef INDEL_INTERVAL_CLUSTERER_TOP_DEFINES_SVH
`define INDEL_INTERVAL_CLUSTERER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IIC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iic check failed");

// Next-cycle implication, checked outside reset.
`define IIC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iic check failed");

`endif

// ===== rtl/iic_pkg.sv =====
// Shared types and constants of the indel interval clusterer.
// No dependencies; used by every module of the block.
`default_nettype none
package iic_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int POS_W   = 28;
  localparam int BOUND_W = 29;
  localparam int CNT_W   = 20;
  localparam int IDX_W   = 10;
  localparam int DVD_W   = POS_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(DVD_W + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Division by ten of a 10-bit value: (x * 205) >> 11 is exact below 1029.
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_PW    = 18;

  localparam logic [1:0] ORIENT_NORMAL = 2'd2;

  localparam logic [1:0] REG_INSERT_SIZE    = 2'd0;
  localparam logic [1:0] REG_SIZE_DEVIATION = 2'd1;
  localparam logic [1:0] REG_READ_LENGTH    = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MERGED = 2'd1;
  localparam logic [1:0] ACT_NEW    = 2'd2;
  localparam logic [1:0] ACT_FULL   = 2'd3;

  localparam logic [9:0] READ_LENGTH_RESET = 10'd100;

  typedef struct packed {
    logic [1:0]       pair_orientation;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [POS_W-1:0] mapping_distance;
    logic             last_pair;
  } pair_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [IDX_W-1:0]   entry_index;
    logic               entry_kind;
    logic [BOUND_W-1:0] entry_left;
    logic [BOUND_W-1:0] entry_right;
    logic [CNT_W-1:0]   entry_count;
    logic [POS_W-1:0]   entry_mean_size;
    logic               final_flag;
  } result_t;

  typedef struct packed {
    logic [BOUND_W-1:0] ivl_left;
    logic [BOUND_W-1:0] ivl_right;
    logic               kind;
    logic [CNT_W-1:0]   count;
    logic [POS_W-1:0]   mean;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_NOMATCH,
    ST_POS_RD,
    ST_POS_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE_NEW,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SORT_RD,
    ST_SORT_CHK,
    ST_SORT_PUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/indel_interval_clusterer_top.sv =====
// Top level of the indel interval clusterer: sequencer, datapath, config.
// Depends on iic_pkg, iic_table, iic_divider and the assertion macro header.
`default_nettype none
`include "indel_interval_clusterer_top_defines.svh"

// One read pair is taken as a beat when start is high and busy is low; busy
// then stays high until the pair is fully handled, and exactly one result
// beat appears on result for a single cycle with result_strobe high. The
// receiver cannot stall, so sample result whenever result_strobe is high.
// A pair that is not of normal orientation or not discordant keeps busy high
// for a single cycle and returns its result in the cycle after that, so a new
// pair can be taken in the cycle in which its result appears. Otherwise the
// sorted table memory is walked entry by entry (read, then compare), so the
// cost grows with occupancy: the scan grows with the entries passed; a merge
// adds a multiply step, a divider start step, a bit-serial division (48
// quotient bits) and a stable re-sort that grows with the entries moved; a new
// entry adds a position search that grows with the entries passed and a shift
// that grows with the entries moved. Configuration writes are accepted in any cycle
// (cfg_ready is always high) but should only be made while the block is idle.
module indel_interval_clusterer_top
  import iic_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire pair_t      pair,
  output logic            result_strobe,
  output result_t         result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [19:0] insert_size;
  logic [15:0] size_deviation;
  logic [9:0]  read_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_size    <= '0;
      size_deviation <= '0;
      read_length    <= READ_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INSERT_SIZE:    insert_size    <= cfg_data[19:0];
        REG_SIZE_DEVIATION: size_deviation <= cfg_data[15:0];
        REG_READ_LENGTH:    read_length    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t state, state_next;
  pair_t  pair_q;
  logic [CW-1:0] used;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos;
  logic [BOUND_W-1:0] c_left, c_right;
  logic               c_kind;
  logic [POS_W-1:0]   c_diff;
  entry_t             ent;
  logic [CNT_W-1:0]   n_r;
  logic [DVD_W-1:0]   prod;

  // Candidate interval arithmetic from the captured pair.
  logic [POS_W-1:0]    diff_c;
  logic                disc_c;
  logic [DIV10_PW-1:0] rl_mul;
  logic [6:0]          shift_c;
  logic [BOUND_W-1:0]  left_c, sum_c, right_c;
  logic                kind_c;
  logic                calc_go;

  always_comb begin
    kind_c  = pair_q.mapping_distance < POS_W'(insert_size);
    diff_c  = kind_c ? POS_W'(insert_size) - pair_q.mapping_distance
                     : pair_q.mapping_distance - POS_W'(insert_size);
    disc_c  = diff_c >= POS_W'({size_deviation, 1'b0});
    rl_mul  = DIV10_PW'(read_length) * DIV10_PW'(DIV10_MUL);
    shift_c = rl_mul[DIV10_PW-1:DIV10_SHIFT];
    left_c  = BOUND_W'(pair_q.left_pos) + BOUND_W'(read_length) - BOUND_W'(shift_c);
    sum_c   = BOUND_W'(pair_q.right_pos) + BOUND_W'(shift_c);
    right_c = (sum_c == '0) ? '0 : sum_c - 1'b1;
    calc_go = (pair_q.pair_orientation == ORIENT_NORMAL) && disc_c;
  end

  // Memory and divider hookups.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;
  logic          div_go, div_done;
  logic [DVD_W-1:0] div_q;
  logic [CW-1:0] ptr_inc, ptr_dec;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] n_inc;
  entry_t        new_ent;
  logic          result_strobe_next;

  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign n_m1    = n_r - 1'b1;

  // Support count of the matched entry after this pair, saturating.
  assign n_inc = (mem_rdata.count >= COUNT_MAX) ? COUNT_MAX : mem_rdata.count + 1'b1;

  always_comb begin
    new_ent.ivl_left  = c_left;
    new_ent.ivl_right = c_right;
    new_ent.kind      = c_kind;
    new_ent.count     = CNT_W'(1);
    new_ent.mean      = c_diff;
  end

  iic_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  iic_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (prod + DVD_W'(c_diff)),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory controls and the result strobe.
  always_comb begin
    state_next         = state;
    mem_we             = 1'b0;
    mem_waddr          = ptr[AW-1:0];
    mem_wdata          = mem_rdata;
    mem_raddr          = ptr[AW-1:0];
    div_go             = 1'b0;
    result_strobe_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CALC;
      end
      ST_CALC: begin
        result_strobe_next = !calc_go;
        state_next = calc_go ? ST_SCAN_RD : ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_next = (ptr == used) ? ST_NOMATCH : ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (c_left > mem_rdata.ivl_right) state_next = ST_SCAN_RD;
        else if (c_right < mem_rdata.ivl_left) state_next = ST_NOMATCH;
        else if (mem_rdata.kind == c_kind) state_next = ST_MUL;
        else state_next = ST_SCAN_RD;
      end
      ST_NOMATCH: begin
        result_strobe_next = (used == CW'(TABLE_DEPTH));
        state_next = (used == CW'(TABLE_DEPTH)) ? ST_IDLE : ST_POS_RD;
      end
      ST_POS_RD: begin
        state_next = (ptr == used) ? ST_SHIFT_RD : ST_POS_CHK;
      end
      ST_POS_CHK: begin
        state_next = (mem_rdata.ivl_left <= c_left) ? ST_POS_RD : ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        mem_raddr  = ptr_dec[AW-1:0];
        state_next = (ptr == pos) ? ST_WRITE_NEW : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        mem_we     = 1'b1;
        state_next = ST_SHIFT_RD;
      end
      ST_WRITE_NEW: begin
        mem_we             = 1'b1;
        mem_waddr          = pos[AW-1:0];
        mem_wdata          = new_ent;
        result_strobe_next = 1'b1;
        state_next         = ST_IDLE;
      end
      ST_MUL: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_go     = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_SORT_RD;
      end
      ST_SORT_RD: begin
        mem_raddr  = ptr_inc[AW-1:0];
        state_next = (ptr_inc == used) ? ST_SORT_PUT : ST_SORT_CHK;
      end
      ST_SORT_CHK: begin
        if (mem_rdata.ivl_left < ent.ivl_left) begin
          mem_we     = 1'b1;
          state_next = ST_SORT_RD;
        end else begin
          state_next = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        mem_we             = 1'b1;
        mem_wdata          = ent;
        result_strobe_next = 1'b1;
        state_next         = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= result_strobe_next;
      case (state)
        ST_IDLE: begin
          if (start) pair_q <= pair;
        end
        ST_CALC: begin
          c_left  <= left_c;
          c_right <= right_c;
          c_kind  <= kind_c;
          c_diff  <= diff_c;
          ptr     <= '0;
          if (!calc_go) begin
            result.action          <= ACT_NONE;
            result.entry_index     <= '0;
            result.entry_kind      <= 1'b0;
            result.entry_left      <= '0;
            result.entry_right     <= '0;
            result.entry_count     <= '0;
            result.entry_mean_size <= '0;
            result.final_flag      <= pair_q.last_pair;
          end
        end
        ST_SCAN_CHK: begin
          if (c_left > mem_rdata.ivl_right) begin
            ptr <= ptr_inc;
          end else if (c_right < mem_rdata.ivl_left) begin
            ptr <= ptr;
          end else if (mem_rdata.kind == c_kind) begin
            // The matched entry narrows to the intersection of both intervals.
            ent.ivl_left  <= (c_left > mem_rdata.ivl_left) ? c_left : mem_rdata.ivl_left;
            ent.ivl_right <= (c_right < mem_rdata.ivl_right) ? c_right
                                                              : mem_rdata.ivl_right;
            ent.kind      <= mem_rdata.kind;
            ent.count     <= n_inc;
            ent.mean      <= mem_rdata.mean;
            n_r           <= n_inc;
          end else begin
            ptr <= ptr_inc;
          end
        end
        ST_NOMATCH: begin
          ptr <= '0;
          if (used == CW'(TABLE_DEPTH)) begin
            result.action          <= ACT_FULL;
            result.entry_index     <= '0;
            result.entry_kind      <= c_kind;
            result.entry_left      <= c_left;
            result.entry_right     <= c_right;
            result.entry_count     <= '0;
            result.entry_mean_size <= c_diff;
            result.final_flag      <= pair_q.last_pair;
          end
        end
        ST_POS_RD: begin
          if (ptr == used) begin
            pos <= ptr;
          end
        end
        ST_POS_CHK: begin
          if (mem_rdata.ivl_left <= c_left) begin
            ptr <= ptr_inc;
          end else begin
            pos <= ptr;
            ptr <= used;
          end
        end
        ST_SHIFT_WR: begin
          ptr <= ptr_dec;
        end
        ST_WRITE_NEW: begin
          used                   <= used + 1'b1;
          result.action          <= ACT_NEW;
          result.entry_index     <= IDX_W'(pos);
          result.entry_kind      <= c_kind;
          result.entry_left      <= c_left;
          result.entry_right     <= c_right;
          result.entry_count     <= CNT_W'(1);
          result.entry_mean_size <= c_diff;
          result.final_flag      <= pair_q.last_pair;
        end
        ST_MUL: begin
          prod <= ent.mean * n_m1;
        end
        ST_DIV_WAIT: begin
          if (div_done) ent.mean <= div_q[POS_W-1:0];
        end
        ST_SORT_CHK: begin
          if (mem_rdata.ivl_left < ent.ivl_left) ptr <= ptr_inc;
        end
        ST_SORT_PUT: begin
          result.action          <= ACT_MERGED;
          result.entry_index     <= IDX_W'(ptr);
          result.entry_kind      <= ent.kind;
          result.entry_left      <= ent.ivl_left;
          result.entry_right     <= ent.ivl_right;
          result.entry_count     <= n_r;
          result.entry_mean_size <= ent.mean;
          result.final_flag      <= pair_q.last_pair;
        end
        default: ;
      endcase
      // The position search also ends when it runs off the used entries.
      if (state == ST_POS_RD && ptr == used) ptr <= used;
    end
  end

  // Checks on the sequencer.
  `IIC_ASSERT_NOW(a_strobe_idle, result_strobe, !busy)
  `IIC_ASSERT_NOW(a_used_bound, 1'b1, used <= CW'(TABLE_DEPTH))
  `IIC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `IIC_ASSERT_NEXT(a_new_grows, state == ST_WRITE_NEW, used == $past(used) + 1'b1)

endmodule
`default_nettype wire

// ===== rtl/iic_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the running mean update.
// Depends on iic_pkg for the operand widths.
`default_nettype none
module iic_divider
  import iic_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  logic [CNT_W:0]       rem;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 ge;
  logic [DVD_W-1:0]     quo;
  logic [CNT_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;

  always_comb begin
    rem_sh  = {rem[CNT_W-1:0], quo[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      // Done marks the cycle right after the last quotient bit is shifted in.
      done <= !go && running && (cnt == DIV_CNT_W'(1));
      if (go) begin
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
        cnt     <= DIV_CNT_W'(DVD_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? rem_sub : rem_sh;
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// ===== rtl/iic_table.sv =====
// Interval table memory: one write port, one read port with registered data.
// Depends on iic_pkg for the entry type.
`default_nettype none
module iic_table
  import iic_pkg::*;
#(
  parameter int DEPTH = DEFAULT_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
